FILE: sv/clle_pkg.sv
package clle_pkg;

    // node store geometry
    localparam int DEPTH      = 16;
    localparam int RESULT_CAP = 16;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTR_W      = $clog2(DEPTH + 1);
    localparam int STEP_W     = $clog2(2 * DEPTH + 1);
    localparam int READ_LIM   = (RESULT_CAP < DEPTH) ? RESULT_CAP : DEPTH;

    // null link, any value of DEPTH or above
    localparam logic [PTR_W-1:0] NIL = PTR_W'(DEPTH);

    // request codes
    typedef enum logic [2:0] {
        REQ_INS_HEAD   = 3'd0,
        REQ_INS_TAIL   = 3'd1,
        REQ_INS_SORTED = 3'd2,
        REQ_DEL_FIRST  = 3'd3,
        REQ_DEL_ALL    = 3'd4,
        REQ_READ       = 3'd5
    } req_t;

    // result status codes
    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_EMPTY     = 2'd3
    } status_t;

    // pointer refers to a real node
    function automatic logic is_node(input logic [PTR_W-1:0] p);
        return p < PTR_W'(DEPTH);
    endfunction

    // bound on nodes visited by one request
    function automatic logic [STEP_W-1:0] step_limit(input req_t r);
        logic [STEP_W-1:0] lim;
        lim = STEP_W'(DEPTH);
        if (r == REQ_DEL_ALL)
            lim = STEP_W'(2 * DEPTH);
        else if (r == REQ_READ)
            lim = STEP_W'(READ_LIM);
        return lim;
    endfunction

endpackage

FILE: sv/cursor_linked_list_engine_core.sv
// Linked-list engine: one singly linked list of signed 32-bit values kept in a
// 16-node store, free nodes held on a stack-like free chain. A small sequencer
// walks the list with a single cursor, reading at most one node per cycle
// through the store's one read port: an insert pops a node off the free chain,
// walks to its place unless it goes at the head, points the new node at the
// rest of the list and then links it in; a delete walks the list and pushes
// each removed node onto the free chain; a readout gives one element per cycle
// while the output register is free or being taken. Requests are taken one at
// a time; the next request is accepted as soon as the last result has been
// loaded into the output register and that register is free or being taken.
// Request codes 6 and 7 are accepted and dropped with no result.
module cursor_linked_list_engine_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          req_type,
    input  logic signed [31:0]  value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic signed [31:0]  elem_out,
    output logic                last
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_WALK   = 5'b00010,
        ST_LINK   = 5'b00100,
        ST_SPLICE = 5'b01000,
        ST_FREE   = 5'b10000
    } state_t;

    // node store
    logic [31:0]                       node_value_reg [clle_pkg::DEPTH];
    logic [clle_pkg::PTR_W-1:0]        node_link_reg  [clle_pkg::DEPTH];

    // sequencer and cursor registers
    state_t                            state_reg, state_next;
    clle_pkg::req_t                    req_reg, req_next;
    logic [31:0]                       val_reg, val_next;
    logic [clle_pkg::IDX_W-1:0]        prev_reg, prev_next;
    logic                              at_head_reg, at_head_next;
    logic [clle_pkg::PTR_W-1:0]        cur_reg, cur_next;
    logic [clle_pkg::IDX_W-1:0]        new_reg, new_next;
    logic [clle_pkg::IDX_W-1:0]        del_reg, del_next;
    logic [clle_pkg::STEP_W-1:0]       steps_reg, steps_next;
    logic [clle_pkg::PTR_W-1:0]        list_head_reg, list_head_next;
    logic [clle_pkg::PTR_W-1:0]        free_head_reg, free_head_next;

    // output register
    logic                              out_valid_reg, out_valid_next;
    clle_pkg::status_t                 status_reg, status_next;
    logic [31:0]                       elem_reg, elem_next;
    logic                              last_reg, last_next;

    // store write controls
    logic                              lk_we;
    logic [clle_pkg::IDX_W-1:0]        lk_waddr;
    logic [clle_pkg::PTR_W-1:0]        lk_wdata;
    logic                              val_we;

    // read port and compare unit
    logic [clle_pkg::PTR_W-1:0]        rd_ptr;
    logic [clle_pkg::IDX_W-1:0]        rd_idx;
    logic [clle_pkg::PTR_W-1:0]        rd_link;
    logic [31:0]                       rd_val;
    logic                              rd_less;
    logic                              rd_match;
    logic                              cur_ok;
    logic [clle_pkg::STEP_W-1:0]       lim;
    logic [clle_pkg::STEP_W-1:0]       steps_inc;
    logic                              out_free;

    // emit controls
    logic                              emit;
    clle_pkg::status_t                 emit_status;
    logic [31:0]                       emit_elem;
    logic                              emit_last;

    // single read address: free head while idle, cursor otherwise
    assign rd_ptr    = (state_reg == ST_IDLE) ? free_head_reg : cur_reg;
    assign rd_idx    = rd_ptr[clle_pkg::IDX_W-1:0];
    assign rd_link   = node_link_reg[rd_idx];
    assign rd_val    = node_value_reg[rd_idx];
    assign rd_less   = $signed(rd_val) < $signed(val_reg);
    assign rd_match  = rd_val == val_reg;
    assign lim       = clle_pkg::step_limit(req_reg);
    assign cur_ok    = clle_pkg::is_node(cur_reg) && (steps_reg < lim);
    assign steps_inc = steps_reg + 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign elem_out  = elem_reg;
    assign last      = last_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        val_next       = val_reg;
        prev_next      = prev_reg;
        at_head_next   = at_head_reg;
        cur_next       = cur_reg;
        new_next       = new_reg;
        del_next       = del_reg;
        steps_next     = steps_reg;
        list_head_next = list_head_reg;
        free_head_next = free_head_reg;
        lk_we          = 1'b0;
        lk_waddr       = prev_reg;
        lk_wdata       = rd_link;
        val_we         = 1'b0;
        emit           = 1'b0;
        emit_status    = clle_pkg::STS_OK;
        emit_elem      = '0;
        emit_last      = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && out_free)
                begin
                    req_next     = clle_pkg::req_t'(req_type);
                    val_next     = value;
                    at_head_next = 1'b1;
                    cur_next     = list_head_reg;
                    steps_next   = '0;
                    if (req_type <= 3'(clle_pkg::REQ_INS_SORTED))
                    begin
                        if (!clle_pkg::is_node(free_head_reg))
                        begin
                            emit        = 1'b1;
                            emit_status = clle_pkg::STS_FULL;
                        end
                        else
                        begin
                            // pop the free chain and store the value
                            val_we         = 1'b1;
                            new_next       = rd_idx;
                            free_head_next = rd_link;
                            state_next     = (req_type == 3'(clle_pkg::REQ_INS_HEAD))
                                           ? ST_LINK : ST_WALK;
                        end
                    end
                    else if (req_type <= 3'(clle_pkg::REQ_READ))
                    begin
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                unique case (req_reg)
                    clle_pkg::REQ_INS_TAIL, clle_pkg::REQ_INS_SORTED:
                    begin
                        if (cur_ok && (req_reg == clle_pkg::REQ_INS_TAIL || rd_less))
                        begin
                            prev_next    = rd_idx;
                            at_head_next = 1'b0;
                            cur_next     = rd_link;
                            steps_next   = steps_inc;
                        end
                        else
                        begin
                            state_next = ST_LINK;
                        end
                    end

                    clle_pkg::REQ_DEL_FIRST:
                    begin
                        if (clle_pkg::is_node(cur_reg) && rd_match)
                        begin
                            // unlink the node under the cursor
                            if (at_head_reg)
                                list_head_next = rd_link;
                            else
                                lk_we = 1'b1;
                            del_next   = rd_idx;
                            cur_next   = rd_link;
                            state_next = ST_FREE;
                        end
                        else if (cur_ok)
                        begin
                            prev_next    = rd_idx;
                            at_head_next = 1'b0;
                            cur_next     = rd_link;
                            steps_next   = steps_inc;
                        end
                        else if (out_free)
                        begin
                            emit        = 1'b1;
                            emit_status = clle_pkg::STS_NOT_FOUND;
                            state_next  = ST_IDLE;
                        end
                    end

                    clle_pkg::REQ_DEL_ALL:
                    begin
                        if (cur_ok)
                        begin
                            steps_next = steps_inc;
                            if (rd_match)
                            begin
                                if (at_head_reg)
                                    list_head_next = rd_link;
                                else
                                    lk_we = 1'b1;
                                del_next   = rd_idx;
                                cur_next   = rd_link;
                                state_next = ST_FREE;
                            end
                            else
                            begin
                                prev_next    = rd_idx;
                                at_head_next = 1'b0;
                                cur_next     = rd_link;
                            end
                        end
                        else if (out_free)
                        begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end

                    clle_pkg::REQ_READ:
                    begin
                        if (out_free)
                        begin
                            emit = 1'b1;
                            if (cur_ok)
                            begin
                                // one element per cycle while the output is free, last at list end or cap
                                emit_elem  = rd_val;
                                emit_last  = !clle_pkg::is_node(rd_link) || (steps_inc >= lim);
                                cur_next   = rd_link;
                                steps_next = steps_inc;
                                if (emit_last)
                                    state_next = ST_IDLE;
                            end
                            else
                            begin
                                emit_status = clle_pkg::STS_EMPTY;
                                state_next  = ST_IDLE;
                            end
                        end
                    end

                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            // new node points at the rest of the list
            ST_LINK:
            begin
                lk_we      = 1'b1;
                lk_waddr   = new_reg;
                lk_wdata   = (req_reg == clle_pkg::REQ_INS_TAIL) ? clle_pkg::NIL : cur_reg;
                state_next = ST_SPLICE;
            end

            // predecessor points at the new node
            ST_SPLICE:
            begin
                if (out_free)
                begin
                    if (at_head_reg)
                        list_head_next = clle_pkg::PTR_W'(new_reg);
                    else
                        lk_we = 1'b1;
                    lk_wdata   = clle_pkg::PTR_W'(new_reg);
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            // push the removed node onto the free chain
            ST_FREE:
            begin
                if (req_reg == clle_pkg::REQ_DEL_ALL)
                begin
                    lk_we          = 1'b1;
                    lk_waddr       = del_reg;
                    lk_wdata       = free_head_reg;
                    free_head_next = clle_pkg::PTR_W'(del_reg);
                    state_next     = ST_WALK;
                end
                else if (out_free)
                begin
                    lk_we          = 1'b1;
                    lk_waddr       = del_reg;
                    lk_wdata       = free_head_reg;
                    free_head_next = clle_pkg::PTR_W'(del_reg);
                    emit           = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register next values
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        elem_next      = elem_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            status_next    = emit_status;
            elem_next      = emit_elem;
            last_next      = emit_last;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            req_reg       <= clle_pkg::REQ_INS_HEAD;
            at_head_reg   <= 1'b1;
            cur_reg       <= clle_pkg::NIL;
            steps_reg     <= '0;
            list_head_reg <= clle_pkg::NIL;
            free_head_reg <= clle_pkg::PTR_W'(clle_pkg::DEPTH - 1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            at_head_reg   <= at_head_next;
            cur_reg       <= cur_next;
            steps_reg     <= steps_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        prev_reg   <= prev_next;
        new_reg    <= new_next;
        del_reg    <= del_next;
        status_reg <= status_next;
        elem_reg   <= elem_next;
        last_reg   <= last_next;
    end

    // link store, reset to a descending free chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < clle_pkg::DEPTH; i++)
            begin
                node_link_reg[i] <= (i == 0) ? clle_pkg::NIL : clle_pkg::PTR_W'(i - 1);
            end
        end
        else if (lk_we)
        begin
            node_link_reg[lk_waddr] <= lk_wdata;
        end
    end

    // value store, written when a node is taken
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            node_value_reg[free_head_reg[clle_pkg::IDX_W-1:0]] <= value;
        end
    end

endmodule

FILE: sv/clle_checker.sv
module clle_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [2:0]          req_type,
    input logic signed [31:0]  value,
    input logic                out_valid,
    input logic                out_ready,
    input logic [1:0]          status,
    input logic signed [31:0]  elem_out,
    input logic                last
);

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(elem_out)
            && $stable(last))
    else $error("stalled result changed");

    // error and empty results close their request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != 2'(clle_pkg::STS_OK)) |-> last)
    else $error("non-ok result without last");

    // only readout elements carry data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != 2'(clle_pkg::STS_OK)) |-> elem_out == 32'sd0)
    else $error("non-ok result with nonzero element");

    // no new request while a readout is still streaming
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |-> !in_ready)
    else $error("request taken during readout");

endmodule

bind cursor_linked_list_engine_core clle_checker u_clle_checker (.*);

FILE: sim/tb_cursor_linked_list_engine_core.sv
`timescale 1ns / 100ps

module tb_cursor_linked_list_engine_core;

    // codes the block accepts and drops
    localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    localparam int IDLE_PCT    = 26;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 64;

    typedef struct {
        clle_pkg::status_t  st;
        logic signed [31:0] elem;
        logic               lst;
    } list_result_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [2:0]         req_type  = 3'd0;
    logic signed [31:0] value     = 32'sd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] elem_out;
    logic               last;

    // shadow copy of the node store, -1 stands for a null link
    logic signed [31:0] node_val [clle_pkg::DEPTH];
    int                 node_nxt [clle_pkg::DEPTH];
    int                 free_top;
    int                 list_top;
    int                 list_len;

    list_result_t pending_results[$];

    bit steady  = 1'b0;
    bit growing = 1'b1;
    int requests_sent   = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int full_seen       = 0;
    int not_found_seen  = 0;
    int empty_reads     = 0;
    int deepest_list    = 0;
    int cycle_count     = 0;

    cursor_linked_list_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .elem_out  (elem_out),
        .last      (last)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // successor of p, where p < 0 means the list head pointer
    function automatic int next_of(input int p);
        return (p < 0) ? list_top : node_nxt[p];
    endfunction

    function automatic void link_after(input int p, input int n);
        if (p < 0)
            list_top = n;
        else
            node_nxt[p] = n;
    endfunction

    function automatic void push_result(input clle_pkg::status_t st,
                                        input logic signed [31:0] e,
                                        input logic l);
        list_result_t r;
        r.st   = st;
        r.elem = e;
        r.lst  = l;
        pending_results.push_back(r);
    endfunction

    // update the shadow list for one request and queue the results it gives
    function automatic void apply_list_request(input logic [2:0] code,
                                               input logic signed [31:0] v);
        int s;
        int prev;
        int cur;
        int steps;
        int k;
        list_result_t tail_res;
        case (code)
            clle_pkg::REQ_INS_HEAD, clle_pkg::REQ_INS_TAIL, clle_pkg::REQ_INS_SORTED:
            begin
                s = free_top;
                if (s < 0)
                begin
                    push_result(clle_pkg::STS_FULL, 32'sd0, 1'b1);
                    full_seen++;
                end
                else
                begin
                    free_top = node_nxt[s];
                    node_val[s] = v;
                    prev = -1;
                    if (code == clle_pkg::REQ_INS_TAIL)
                    begin
                        for (steps = 0; steps < clle_pkg::DEPTH && next_of(prev) >= 0;
                             steps++)
                            prev = next_of(prev);
                    end
                    else if (code == clle_pkg::REQ_INS_SORTED)
                    begin
                        // stop before the first element not less than v
                        for (steps = 0; steps < clle_pkg::DEPTH && next_of(prev) >= 0 &&
                             node_val[next_of(prev)] < v; steps++)
                            prev = next_of(prev);
                    end
                    node_nxt[s] = (code == clle_pkg::REQ_INS_TAIL) ? -1 : next_of(prev);
                    link_after(prev, s);
                    list_len++;
                    if (list_len > deepest_list)
                        deepest_list = list_len;
                    push_result(clle_pkg::STS_OK, 32'sd0, 1'b1);
                end
            end
            clle_pkg::REQ_DEL_FIRST:
            begin
                prev = -1;
                for (steps = 0; steps < clle_pkg::DEPTH && next_of(prev) >= 0 &&
                     node_val[next_of(prev)] != v; steps++)
                    prev = next_of(prev);
                cur = next_of(prev);
                if (cur >= 0 && node_val[cur] == v)
                begin
                    link_after(prev, node_nxt[cur]);
                    node_nxt[cur] = free_top;
                    free_top = cur;
                    list_len--;
                    push_result(clle_pkg::STS_OK, 32'sd0, 1'b1);
                end
                else
                begin
                    push_result(clle_pkg::STS_NOT_FOUND, 32'sd0, 1'b1);
                    not_found_seen++;
                end
            end
            clle_pkg::REQ_DEL_ALL:
            begin
                prev = -1;
                for (steps = 0; steps < 2 * clle_pkg::DEPTH && next_of(prev) >= 0; steps++)
                begin
                    cur = next_of(prev);
                    if (node_val[cur] == v)
                    begin
                        link_after(prev, node_nxt[cur]);
                        node_nxt[cur] = free_top;
                        free_top = cur;
                        list_len--;
                    end
                    else
                        prev = cur;
                end
                push_result(clle_pkg::STS_OK, 32'sd0, 1'b1);
            end
            clle_pkg::REQ_READ:
            begin
                cur = list_top;
                k = 0;
                while (k < clle_pkg::RESULT_CAP && k < clle_pkg::DEPTH && cur >= 0)
                begin
                    push_result(clle_pkg::STS_OK, node_val[cur], 1'b0);
                    k++;
                    cur = node_nxt[cur];
                end
                if (k == 0)
                begin
                    push_result(clle_pkg::STS_EMPTY, 32'sd0, 1'b1);
                    empty_reads++;
                end
                else
                begin
                    tail_res = pending_results.pop_back();
                    tail_res.lst = 1'b1;
                    pending_results.push_back(tail_res);
                end
            end
            default:
            begin
                // unused codes give nothing
            end
        endcase
    endfunction

    // present one request, wait for it to be taken, then predict
    task automatic issue_request(input logic [2:0] code, input logic signed [31:0] v);
        int gap;
        gap = 0;
        if (!steady)
            while ($urandom_range(0, 99) < IDLE_PCT)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= code;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_list_request(code, v);
        requests_sent++;
        @(negedge clk);
    endtask

    // compare every taken result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d elem %0d last %0b",
                             status, elem_out, last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st || elem_out !== want.elem || last !== want.lst)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d elem %0d last %0b, got %0d %0d %0b",
                                 want.st, want.elem, want.lst, status, elem_out, last);
                end
            end
        end
    end

    // a read and both deletes on an empty list, plus a dropped code
    task automatic test_empty_list();
        issue_request(clle_pkg::REQ_READ, 32'sd0);
        issue_request(clle_pkg::REQ_DEL_FIRST, 32'sd5);
        issue_request(clle_pkg::REQ_DEL_ALL, 32'sd5);
        issue_request(REQ_UNUSED_7, VAL_MAX);
    endtask

    // fill the store with extremes and duplicates, overflow it, read it all
    task automatic test_fill_to_full();
        issue_request(clle_pkg::REQ_INS_HEAD, VAL_MIN);
        issue_request(clle_pkg::REQ_INS_TAIL, VAL_MAX);
        issue_request(clle_pkg::REQ_INS_SORTED, 32'sd0);
        issue_request(clle_pkg::REQ_INS_SORTED, -32'sd1);
        issue_request(clle_pkg::REQ_INS_SORTED, VAL_MAX - 1);
        issue_request(clle_pkg::REQ_INS_SORTED, VAL_MIN);
        issue_request(clle_pkg::REQ_INS_HEAD, 32'sd3);
        issue_request(clle_pkg::REQ_INS_TAIL, 32'sd3);
        issue_request(clle_pkg::REQ_INS_SORTED, 32'sd3);
        issue_request(clle_pkg::REQ_INS_SORTED, 32'sd3);
        issue_request(clle_pkg::REQ_INS_HEAD, -32'sd1);
        issue_request(clle_pkg::REQ_INS_TAIL, 32'sd0);
        issue_request(clle_pkg::REQ_INS_SORTED, 32'sd42);
        issue_request(clle_pkg::REQ_INS_SORTED, -32'sd42);
        issue_request(clle_pkg::REQ_INS_HEAD, VAL_MAX);
        issue_request(clle_pkg::REQ_INS_SORTED, VAL_MAX);
        issue_request(clle_pkg::REQ_INS_TAIL, 32'sd1);
        issue_request(clle_pkg::REQ_READ, 32'sd0);
    endtask

    // remove duplicates, an extreme, and miss once
    task automatic test_deletes();
        issue_request(clle_pkg::REQ_DEL_ALL, 32'sd3);
        issue_request(clle_pkg::REQ_DEL_FIRST, VAL_MIN);
        issue_request(clle_pkg::REQ_DEL_FIRST, 32'sd12345);
    endtask

    // random traffic that swings the list between nearly empty and full
    task automatic test_random_traffic(input int count);
        int done;
        int roll;
        int ins_pct;
        int hops;
        int cur;
        logic [2:0] code;
        logic signed [31:0] v;
        done = 0;
        while (done < count)
        begin
            if (list_len >= clle_pkg::DEPTH)
                growing = 1'b0;
            else if (list_len <= 2)
                growing = 1'b1;
            ins_pct = growing ? 55 : 22;

            roll = $urandom_range(0, 99);
            if (roll < 4)
                code = $urandom_range(0, 1) ? REQ_UNUSED_6 : REQ_UNUSED_7;
            else if (roll < 4 + ins_pct)
                code = 3'($urandom_range(0, 2));
            else if (roll < 86)
                code = ($urandom_range(0, 3) == 0) ? clle_pkg::REQ_DEL_ALL
                                                   : clle_pkg::REQ_DEL_FIRST;
            else
                code = clle_pkg::REQ_READ;

            // mostly a small pool so that deletes and sorted inserts hit equals
            roll = $urandom_range(0, 99);
            if (roll < 60)
                v = int'($urandom_range(0, 9)) - 4;
            else if (roll < 72)
            begin
                case ($urandom_range(0, 4))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = VAL_MAX - 1;
                    3: v = -32'sd1;
                    default: v = 32'sd0;
                endcase
            end
            else
                v = $urandom();

            // deletes usually aim at an element that is present
            if ((code == clle_pkg::REQ_DEL_FIRST || code == clle_pkg::REQ_DEL_ALL) &&
                list_len > 0 && $urandom_range(0, 99) < 70)
            begin
                cur = list_top;
                hops = $urandom_range(0, list_len - 1);
                repeat (hops)
                    cur = node_nxt[cur];
                v = node_val[cur];
            end

            issue_request(code, v);
            if (code != REQ_UNUSED_6 && code != REQ_UNUSED_7)
                done++;
        end
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_steady_burst(input int count);
        steady = 1'b1;
        test_random_traffic(count);
        steady = 1'b0;
    endtask

    initial
    begin : main_flow
        int i;
        for (i = 0; i < clle_pkg::DEPTH; i++)
        begin
            node_val[i] = 32'sd0;
            node_nxt[i] = i - 1;
        end
        free_top = clle_pkg::DEPTH - 1;
        list_top = -1;
        list_len = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_list();
        test_fill_to_full();
        test_deletes();
        test_random_traffic(260);
        test_steady_burst(110);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("sent %0d requests, checked %0d results, longest list %0d of %0d nodes",
                 requests_sent, results_checked, deepest_list, clle_pkg::DEPTH);
        $display("store full %0d times, delete misses %0d, empty readouts %0d, mismatches %0d",
                 full_seen, not_found_seen, empty_reads, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
